>>> src/longest_earlier_suffix_match_unit_assert.svh
// Assertion macros used by the checker file lesm_chk.sv.
`ifndef LONGEST_EARLIER_SUFFIX_MATCH_UNIT_ASSERT_SVH
`define LONGEST_EARLIER_SUFFIX_MATCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LESM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lesm assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LESM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lesm assertion failed");

`endif

>>> src/lesm_pkg.sv
`timescale 1ns / 1ps
package lesm_pkg;

  localparam int MAX_LEN     = 256;
  localparam int SYMBOL_BITS = 8;
  // fill count and suffix lengths both reach MAX_LEN
  localparam int CNT_W       = $clog2(MAX_LEN + 1);
  localparam int LEN_W       = CNT_W;

  typedef struct packed {
    logic [7:0] symbol;
    logic       restart;
    logic       keep;
  } in_t;

  typedef struct packed {
    logic [7:0] match_len;
    logic       history_full;
  } out_t;

  // beat travelling along the cell chain
  typedef struct packed {
    logic                   valid;
    logic [SYMBOL_BITS-1:0] symbol;
    logic [CNT_W-1:0]       n;
    logic                   store;
    logic                   full;
    logic [LEN_W-1:0]       left_len;
    logic [LEN_W-1:0]       best;
  } tok_t;

  function automatic logic [7:0] sat_len(input logic [LEN_W-1:0] len);
    logic [LEN_W+7:0] w;
    w = {8'd0, len};
    sat_len = (w > (LEN_W + 8)'(255)) ? 8'hFF : w[7:0];
  endfunction

endpackage

>>> src/lesm_cell.sv
`timescale 1ns / 1ps
module lesm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [lesm_pkg::CNT_W-1:0] idx,
  input  lesm_pkg::tok_t             left,
  output lesm_pkg::tok_t             right
);

  logic [lesm_pkg::SYMBOL_BITS-1:0] sym;
  logic [lesm_pkg::LEN_W-1:0]       len;
  logic                             active;
  logic                             hit;
  logic [lesm_pkg::LEN_W-1:0]       v;
  logic [lesm_pkg::LEN_W-1:0]       best_next;

  always_comb begin
    active    = (idx < left.n);
    hit       = active && (sym == left.symbol);
    v         = hit ? (left.left_len + lesm_pkg::LEN_W'(1)) : '0;
    best_next = (v > left.best) ? v : left.best;
  end

  // neighbour gets this cell's length from before the update
  always_ff @(posedge clk) begin
    if (advance) begin
      right.symbol   <= left.symbol;
      right.n        <= left.n;
      right.store    <= left.store;
      right.full     <= left.full;
      right.left_len <= len;
      right.best     <= best_next;
    end
    if (rst) begin
      right.valid <= 1'b0;
    end else if (advance) begin
      right.valid <= left.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && left.valid && left.store) begin
      if (active) begin
        len <= v;
      end else if (idx == left.n) begin
        sym <= left.symbol;
        len <= '0;
      end
    end
  end

endmodule

>>> src/longest_earlier_suffix_match_unit.sv
`timescale 1ns / 1ps
// Longest earlier suffix match. Each item beat appends one symbol (or only
// probes it when keep is low) and returns the length of the longest suffix of
// the string that also ends at an earlier position, saturated to 255. The
// string lives in a chain of MAX_LEN cells, one symbol and one running
// common-suffix length per cell; a beat walks down the chain one cell per
// cycle while the chain advances, each cell updating its length from its left
// neighbour's old value and folding its result into a running maximum. A new
// item is taken every cycle unless a result is held off; the result leaves
// from the last cell's register. A stalled result freezes the whole
// chain, so item_ready follows the output register. restart empties
// the history before the symbol is used; a kept symbol arriving at a full
// history is dropped and flagged by history_full.
module longest_earlier_suffix_match_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  lesm_pkg::in_t  item,
  output logic           result_valid,
  input  logic           result_ready,
  output lesm_pkg::out_t result
);

  lesm_pkg::tok_t chain [0:lesm_pkg::MAX_LEN];

  logic [lesm_pkg::CNT_W-1:0] fill_count;
  logic [lesm_pkg::CNT_W-1:0] fill_count_next;
  logic [lesm_pkg::CNT_W-1:0] n_eff;
  logic                       full;
  logic                       store;
  logic                       advance;

  // whole chain moves together; it stops only on an untaken result
  assign advance    = !result_valid || result_ready;
  assign item_ready = advance;

  always_comb begin
    n_eff = item.restart ? '0 : fill_count;
    full  = item.keep && (n_eff >= lesm_pkg::CNT_W'(lesm_pkg::MAX_LEN));
    store = item.keep && !full;
    fill_count_next = store ? (n_eff + lesm_pkg::CNT_W'(1)) : n_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (item_valid && item_ready) begin
      fill_count <= fill_count_next;
    end
  end

  // entry beat: cell 0 sees a zero left length, so a hit there scores 1
  always_comb begin
    chain[0].valid    = item_valid;
    chain[0].symbol   = item.symbol[lesm_pkg::SYMBOL_BITS-1:0];
    chain[0].n        = n_eff;
    chain[0].store    = store;
    chain[0].full     = full;
    chain[0].left_len = '0;
    chain[0].best     = '0;
  end

  for (genvar q = 0; q < lesm_pkg::MAX_LEN; q++) begin : g_cell
    lesm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .idx     (lesm_pkg::CNT_W'(q)),
      .left    (chain[q]),
      .right   (chain[q+1])
    );
  end

  // last cell's stage register is the output register
  assign result_valid        = chain[lesm_pkg::MAX_LEN].valid;
  assign result.match_len    = lesm_pkg::sat_len(chain[lesm_pkg::MAX_LEN].best);
  assign result.history_full = chain[lesm_pkg::MAX_LEN].full;

endmodule

>>> src/lesm_chk.sv
`timescale 1ns / 1ps
`include "longest_earlier_suffix_match_unit_assert.svh"
module lesm_chk (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_ready,
  input logic           result_valid,
  input logic           result_ready,
  input lesm_pkg::out_t result
);

  // a held result keeps its value
  `LESM_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(result))

  // input side stalls exactly when a result waits untaken
  `LESM_ASSERT_NOW(a_stall, 1'b1, item_ready == (!result_valid || result_ready))

  // nothing leaves straight after reset
  `LESM_ASSERT_NOW(a_rst, $past(rst), !result_valid)

  // an item refused is only refused behind a waiting result
  `LESM_ASSERT_NOW(a_refuse, item_valid && !item_ready, result_valid)

endmodule

bind longest_earlier_suffix_match_unit lesm_chk u_lesm_chk (.*);

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;

  // drain time covers result beats still in the cell chain or held off
  localparam int DRAIN_CYCLES = 2 * lesm_pkg::MAX_LEN + 64;
  localparam int IDLE_LIMIT   = 20 * lesm_pkg::MAX_LEN;
  localparam int ITEM_TARGET  = 1150;

  // hand-picked opening beats, packed as {symbol, restart, keep}
  localparam logic [9:0] OPENING [21] = '{
    {8'h00, 1'b1, 1'b0},  // restart with a probe on an empty history
    {8'h00, 1'b0, 1'b1},
    {8'h00, 1'b0, 1'b1},
    {8'hFF, 1'b0, 1'b1},
    {8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b1},
    {8'hFF, 1'b0, 1'b1},
    {8'hFF, 1'b0, 1'b0},
    {8'hFF, 1'b1, 1'b0},  // restart with a probe after a history was built
    {8'hAA, 1'b1, 1'b1},
    {8'h55, 1'b0, 1'b1},
    {8'hAA, 1'b0, 1'b1},
    {8'h55, 1'b0, 1'b1},
    {8'hAA, 1'b0, 1'b0},
    {8'h55, 1'b0, 1'b0},  // probes must leave the history alone
    {8'hAA, 1'b0, 1'b1},
    {8'hFF, 1'b1, 1'b1},
    {8'hFF, 1'b0, 1'b1},
    {8'hFF, 1'b0, 1'b0},
    {8'h01, 1'b0, 1'b1},
    {8'h80, 1'b0, 1'b1}
  };

  logic           clk          = 1'b0;
  logic           rst          = 1'b1;
  logic           item_valid   = 1'b0;
  logic           item_ready;
  lesm_pkg::in_t  item         = '0;
  logic           result_valid;
  logic           result_ready = 1'b0;
  lesm_pkg::out_t result;

  longest_earlier_suffix_match_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #5 clk = ~clk;

  lesm_pkg::in_t  symbol_queue[$];      // beats still to be sent
  lesm_pkg::out_t expected_matches[$];  // predicted results, oldest first
  int             errors = 0;

  // shadow of the string held by the block
  logic [lesm_pkg::SYMBOL_BITS-1:0] shadow_sym [lesm_pkg::MAX_LEN];
  int                               shadow_len [lesm_pkg::MAX_LEN];
  int                               kept_count;

  // Score each stored cell from its left neighbour's old length, walking down so each
  // cell still sees the old value; kept beats store the scores; answer is the best.
  function automatic lesm_pkg::out_t predict_match(lesm_pkg::in_t it);
    logic [lesm_pkg::SYMBOL_BITS-1:0] c;
    int             n;
    int             p;
    int             q;
    int             v;
    int             best;
    bit             full;
    bit             store;
    lesm_pkg::out_t r;
    c = it.symbol[lesm_pkg::SYMBOL_BITS-1:0];
    if (it.restart) kept_count = 0;
    n     = kept_count;
    full  = it.keep && (n >= lesm_pkg::MAX_LEN);
    store = it.keep && !full;
    best  = 0;
    for (p = n; p > 0; p--) begin
      q = p - 1;
      if (shadow_sym[q] == c) v = (q > 0) ? shadow_len[q-1] + 1 : 1;
      else v = 0;
      if (v > best) best = v;
      if (store) shadow_len[q] = v;
    end
    if (store) begin
      shadow_sym[n] = c;
      shadow_len[n] = 0;
      kept_count    = n + 1;
    end
    r.match_len    = (best > 255) ? 8'd255 : 8'(best);
    r.history_full = full;
    return r;
  endfunction

  // One string: symbols drawn from alpha values around a random base (a small
  // alpha makes matches common), with some probes and optional mid-run restarts.
  task automatic queue_string(input int len, input int alpha, input int probe_pct,
                              input int restart_pct, input bit first_restart);
    int            k;
    logic [7:0]    base;
    lesm_pkg::in_t it;
    base = 8'($urandom_range(0, 255));
    for (k = 0; k < len; k++) begin
      it.symbol  = base ^ 8'($urandom_range(0, alpha - 1));
      it.restart = (k == 0) ? first_restart : ($urandom_range(0, 99) < restart_pct);
      it.keep    = ($urandom_range(0, 99) >= probe_pct);
      symbol_queue.push_back(it);
    end
  endtask

  // Driver: bursts of beats with random gaps; the next beat follows the
  // accepted one straight away inside a burst.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (item_valid && item_ready) expected_matches.push_back(predict_match(item));
      if (!item_valid || item_ready) begin
        if (gap_left > 0) begin
          item_valid <= 1'b0;
          gap_left   <= gap_left - 1;
        end else if (symbol_queue.size() > 0) begin
          item       <= symbol_queue.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            // a third of the bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and drives ready from a rotating
  // stall pattern that is swapped whenever pat_age reaches its top value.
  logic [15:0] stall_pat = '1;
  logic [5:0]  pat_age   = '0;

  always @(posedge clk) begin
    lesm_pkg::out_t want;
    logic [15:0]    pat;
    if (rst) begin
      result_ready <= 1'b0;
      stall_pat    <= '1;
      pat_age      <= '0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_matches.size() == 0) begin
          $display("%0t: result beat with nothing expected: match_len %0d history_full %0b",
                   $time, result.match_len, result.history_full);
          errors++;
        end else begin
          want = expected_matches.pop_front();
          if (result.match_len !== want.match_len) begin
            $display("%0t: match_len expected %0d actual %0d",
                     $time, want.match_len, result.match_len);
            errors++;
          end
          if (result.history_full !== want.history_full) begin
            $display("%0t: history_full expected %0b actual %0b",
                     $time, want.history_full, result.history_full);
            errors++;
          end
        end
      end
      pat = stall_pat;
      if (pat_age == '1) begin
        case ($urandom_range(0, 3))
          0: pat = '1;                                         // no stalls
          1: pat = 16'($urandom) | 16'h0001;                   // about half
          2: pat = 16'h0001;                                   // heavy stall
          default: pat = 16'($urandom) | 16'($urandom) | 16'h0001;
        endcase
      end
      result_ready <= pat[0];
      stall_pat    <= {pat[0], pat[15:1]};
      pat_age      <= pat_age + 1'b1;
    end
  end

  // Watchdog on cycles where neither side moves a beat.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    int long_runs;
    for (i = 0; i < lesm_pkg::MAX_LEN; i++) begin
      shadow_sym[i] = '0;
      shadow_len[i] = 0;
    end
    kept_count = 0;
    long_runs  = 0;

    for (i = 0; i < 21; i++) symbol_queue.push_back(lesm_pkg::in_t'(OPENING[i]));

    // one symbol repeated past capacity: fills the history, saturates the
    // match length and raises history_full on the extra kept beats
    queue_string(lesm_pkg::MAX_LEN + 40, 1, 10, 0, 1'b1);

    while (symbol_queue.size() < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: queue_string($urandom_range(1, 40), $urandom_range(1, 4),
                                       25, 0, 1'b1);
        6: queue_string($urandom_range(1, 10), 256, 50, 50, 1'($urandom_range(0, 1)));
        7: begin
          if (long_runs < 1) begin
            queue_string($urandom_range(lesm_pkg::MAX_LEN, lesm_pkg::MAX_LEN + 40),
                         $urandom_range(1, 3), 10, 0, 1'b1);
            long_runs++;
          end else begin
            queue_string($urandom_range(20, 60), 2, 20, 0, 1'b1);
          end
        end
        8: queue_string($urandom_range(1, 20), $urandom_range(1, 3), 25, 0, 1'b0);
        default: queue_string($urandom_range(5, 40), $urandom_range(1, 4), 25, 10, 1'b1);
      endcase
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (symbol_queue.size() != 0 || item_valid) @(posedge clk);
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/lesm_pkg.sv
src/lesm_cell.sv
src/longest_earlier_suffix_match_unit.sv
src/lesm_chk.sv
test/tb.sv
